// ===== rtl/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types and constants of the direction cosine matrix update block:
// transfer payloads, matrix store request and multiplier request.
// ----------------------------------------------------------------------------
package dcm_pkg;

	// word width of matrix entries, vector components and results
	localparam int WORD_W = 32;

	// matrix store geometry, row-major 3x3
	localparam int MAT_DEPTH = 9;
	localparam int MAT_AW = $clog2(MAT_DEPTH);

	// shared multiplier operand and product widths
	localparam int MUL_W = WORD_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	// 1.0 in Q3.28
	localparam logic [WORD_W-1:0] MAT_ONE = 32'h1000_0000;

	// reset value of the step time register, about 0.01 s in Q0.32
	localparam logic [WORD_W-1:0] STEP_TIME_RST = 32'd42949673;

	// item modes
	typedef enum logic [1:0] {
		MODE_INTEGRATE = 2'd0,
		MODE_ROTATE    = 2'd1,
		MODE_RELOAD    = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [WORD_W-1:0] vec_x;
		logic signed [WORD_W-1:0] vec_y;
		logic signed [WORD_W-1:0] vec_z;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] out_x;
		logic signed [WORD_W-1:0] out_y;
		logic signed [WORD_W-1:0] out_z;
	} out_item_t;

	// request from the sequencer to the matrix store
	typedef struct packed {
		logic              rd_en;
		logic [MAT_AW-1:0] rd_addr;
		logic              wr_en;
		logic [MAT_AW-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic              clr;
	} ram_req_t;

	// request from the sequencer to the shared multiplier
	typedef struct packed {
		logic                    en;
		logic signed [MUL_W-1:0] op_a;
		logic signed [MUL_W-1:0] op_b;
	} mul_req_t;

endpackage

// ===== rtl/dcm_attitude_update.sv =====
// ----------------------------------------------------------------------------
// dcm_attitude_update
// A rotate item gives its result in the output register; an integrate item
//   writes the new matrix back and a reload item only clears the matrix store.
// Items are taken one at a time, with twelve products per matrix column on
//   integrate, all on the single shared multiplier.
// Reset: the matrix reads as the identity, step time returns to about 0.01 s
//   and the output register empties.
// Direction cosine matrix attitude update around a nine-word matrix store.
// ----------------------------------------------------------------------------
module dcm_attitude_update
	import dcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	logic [WORD_W-1:0]        step_time_q;
	logic                     out_valid_q;
	out_item_t                out_data_q;
	logic                     res_valid;
	logic                     res_ready;
	out_item_t                res_data;
	ram_req_t                 ram_req;
	logic [WORD_W-1:0]        rd_data;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] prod_q;

	// hold the step time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= STEP_TIME_RST;
		end else if (cfg_we) begin
			step_time_q <= cfg_wdata;
		end
	end

	// output register: take a new result once the old one has been transferred
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	dcm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_time (step_time_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.ram_req   (ram_req),
		.rd_data   (rd_data),
		.mul_req   (mul_req),
		.prod_q    (prod_q)
	);

	dcm_mat_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	dcm_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

endmodule

// ===== rtl/dcm_mat_ram.sv =====
// ----------------------------------------------------------------------------
// dcm_mat_ram
// Matrix store: nine words, one write and one read port, registered read.
// Per-entry valid bits make an unwritten entry read as the identity; a
// clear request drops every valid bit at once to reload the identity.
// ----------------------------------------------------------------------------
module dcm_mat_ram
	import dcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ram_req_t          req,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0]    mem [MAT_DEPTH];
	logic [MAT_DEPTH-1:0] valid_q;
	logic [WORD_W-1:0]    raw_q;
	logic                 hit_q;
	logic                 diag_q;

	// write and read the storage array
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_q <= mem[req.rd_addr];
		end
	end

	// track written entries and register the read-side selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
			diag_q  <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				hit_q  <= valid_q[req.rd_addr];
				diag_q <= (req.rd_addr == MAT_AW'(0)) || (req.rd_addr == MAT_AW'(4))
					|| (req.rd_addr == MAT_AW'(8));
			end
		end
	end

	// fall back to the identity for entries not yet written
	assign rd_data = hit_q ? raw_q : (diag_q ? MAT_ONE : '0);

endmodule

// ===== rtl/dcm_mul.sv =====
// ----------------------------------------------------------------------------
// dcm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dcm_mul
	import dcm_pkg::*;
(
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod_q
);

	// multiply and hold the product
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.op_a * req.op_b;
		end
	end

endmodule

// ===== rtl/dcm_seq.sv =====
// ----------------------------------------------------------------------------
// dcm_seq
// Sequencer and arithmetic around the matrix store. Works one column at a
// time: read the three entries, run the products through the shared
// multiplier, write the new column back (integrate) or sum into one
// result component (rotate); a reload item clears the store instead.
// ----------------------------------------------------------------------------
module dcm_seq
	import dcm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [WORD_W-1:0]        step_time,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	output logic                     res_valid,
	input  logic                     res_ready,
	output out_item_t                res_data,
	output ram_req_t                 ram_req,
	input  logic [WORD_W-1:0]        rd_data,
	output mul_req_t                 mul_req,
	input  logic signed [PROD_W-1:0] prod_q
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_RWAIT,
		S_MUL,
		S_DRAIN,
		S_EMIT
	} state_t;

	// product kinds: rate terms, time scaling halves, rotation terms
	typedef enum logic [2:0] {
		K_A,
		K_B,
		K_C,
		K_D,
		K_R
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] row;
	} op_t;

	localparam logic [3:0] LAST_OP_INT = 4'd11;
	localparam logic [3:0] LAST_OP_ROT = 4'd2;
	localparam logic [3:0] FIRST_TIME_OP = 4'd6;
	localparam logic [1:0] LAST_IDX = 2'd2;
	localparam int SUM_W = 51;
	localparam int T1_W = 48;
	localparam int D_W = 49;
	localparam int HI_W = 57;
	localparam int ACC_W = 58;
	localparam int ROT_W = 38;

	state_t            state_q;
	logic [1:0]        mode_q;
	logic [1:0]        col_idx_q;
	logic [1:0]        k_q;
	logic [3:0]        m_q;
	logic [3:0]        m_rel;
	logic              rd_pend_s1;
	logic [1:0]        rd_row_s1;
	logic              op_vld_s1;
	op_t               op_s1;
	logic              fin_vld_s2;
	logic [1:0]        fin_row_s2;
	op_t               issue_op;
	logic [3:0]        last_op;

	in_item_t          vec_q;
	logic [WORD_W-1:0] col_q [3];
	logic [T1_W-1:0]   t1_q;
	logic [D_W-1:0]    d_q [3];
	logic [HI_W-1:0]   hi_q;
	logic [ACC_W-1:0]  sum_q;
	logic [ROT_W-1:0]  racc_q;
	logic [WORD_W-1:0] res_part_q [3];

	logic [ROT_W-1:0]  term_ext;
	logic [ROT_W-1:0]  rot_sum;
	logic [SUM_W-1:0]  fin_sum;
	logic [WORD_W-1:0] fin_word;

	// row-major address of an entry
	function automatic logic [MAT_AW-1:0] mat_addr(input logic [1:0] r, input logic [1:0] c);
		mat_addr = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
	endfunction

	// first and second partner rows of each row's update
	function automatic logic [1:0] row_p(input logic [1:0] r);
		case (r)
			2'd0:    row_p = 2'd1;
			2'd1:    row_p = 2'd2;
			default: row_p = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] row_q(input logic [1:0] r);
		case (r)
			2'd0:    row_q = 2'd2;
			2'd1:    row_q = 2'd0;
			default: row_q = 2'd1;
		endcase
	endfunction

	// vector component by index: x, y, z
	function automatic logic [WORD_W-1:0] vec_sel(input in_item_t v, input logic [1:0] i);
		case (i)
			2'd0:    vec_sel = v.vec_x;
			2'd1:    vec_sel = v.vec_y;
			default: vec_sel = v.vec_z;
		endcase
	endfunction

	// rate that weights the first partner row: wz, wx, wy
	function automatic logic [WORD_W-1:0] rate_a(input in_item_t v, input logic [1:0] r);
		case (r)
			2'd0:    rate_a = v.vec_z;
			2'd1:    rate_a = v.vec_x;
			default: rate_a = v.vec_y;
		endcase
	endfunction

	// rate that weights the second partner row: wy, wz, wx
	function automatic logic [WORD_W-1:0] rate_b(input in_item_t v, input logic [1:0] r);
		case (r)
			2'd0:    rate_b = v.vec_y;
			2'd1:    rate_b = v.vec_z;
			default: rate_b = v.vec_x;
		endcase
	endfunction

	// clamp to the signed word range
	function automatic logic [WORD_W-1:0] sat_word(input logic [SUM_W-1:0] v);
		logic [WORD_W-1:0] r;
		if (&v[SUM_W-1:WORD_W-1] || ~|v[SUM_W-1:WORD_W-1]) begin
			r = v[WORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// pick the product to issue this cycle
	assign m_rel = m_q - FIRST_TIME_OP;
	assign last_op = (mode_q == MODE_ROTATE) ? LAST_OP_ROT : LAST_OP_INT;

	always_comb begin
		issue_op.kind = K_R;
		issue_op.row  = m_q[1:0];
		if (mode_q == MODE_INTEGRATE) begin
			if (m_q < FIRST_TIME_OP) begin
				issue_op.kind = m_q[0] ? K_B : K_A;
				issue_op.row  = m_q[2:1];
			end else begin
				issue_op.kind = m_rel[0] ? K_D : K_C;
				issue_op.row  = m_rel[2:1];
			end
		end
	end

	// steer the multiplier operands
	always_comb begin
		mul_req.en = (state_q == S_MUL);
		case (issue_op.kind)
			K_A: begin
				mul_req.op_a = MUL_W'($signed(rate_a(vec_q, issue_op.row)));
				mul_req.op_b = $signed({col_q[row_p(issue_op.row)][WORD_W-1],
					col_q[row_p(issue_op.row)]});
			end
			K_B: begin
				mul_req.op_a = MUL_W'($signed(rate_b(vec_q, issue_op.row)));
				mul_req.op_b = $signed({col_q[row_q(issue_op.row)][WORD_W-1],
					col_q[row_q(issue_op.row)]});
			end
			K_C: begin
				mul_req.op_a = $signed({{8{d_q[issue_op.row][D_W-1]}},
					d_q[issue_op.row][D_W-1:24]});
				mul_req.op_b = $signed({1'b0, step_time});
			end
			K_D: begin
				mul_req.op_a = $signed({9'd0, d_q[issue_op.row][23:0]});
				mul_req.op_b = $signed({1'b0, step_time});
			end
			K_R: begin
				mul_req.op_a = $signed({col_q[issue_op.row][WORD_W-1], col_q[issue_op.row]});
				mul_req.op_b = MUL_W'($signed(vec_sel(vec_q, issue_op.row)));
			end
			default: begin
				mul_req.op_a = '0;
				mul_req.op_b = '0;
			end
		endcase
	end

	// rotation term is the product floored to Q16.16
	assign term_ext = {{2{prod_q[63]}}, prod_q[63:28]};
	assign rot_sum = racc_q + term_ext;

	// new entry: old entry plus the scaled step, floored by 2^8 more
	assign fin_sum = {{(SUM_W-WORD_W){col_q[fin_row_s2][WORD_W-1]}}, col_q[fin_row_s2]}
		+ {sum_q[ACC_W-1], sum_q[ACC_W-1:8]};
	assign fin_word = sat_word(fin_sum);

	// matrix store requests
	always_comb begin
		ram_req.rd_en   = (state_q == S_RD);
		ram_req.rd_addr = mat_addr(k_q, col_idx_q);
		ram_req.wr_en   = fin_vld_s2;
		ram_req.wr_addr = mat_addr(fin_row_s2, col_idx_q);
		ram_req.wr_data = fin_word;
		ram_req.clr     = (state_q == S_IDLE) && in_valid && (in_data.mode == MODE_RELOAD);
	end

	assign in_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res_data.out_x = res_part_q[0];
	assign res_data.out_y = res_part_q[1];
	assign res_data.out_z = res_part_q[2];

	// sequence reads, products and write-back column by column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_INTEGRATE;
			col_idx_q  <= '0;
			k_q        <= '0;
			m_q        <= '0;
			rd_pend_s1 <= 1'b0;
			rd_row_s1  <= '0;
			op_vld_s1  <= 1'b0;
			op_s1      <= '{kind: K_A, row: 2'd0};
			fin_vld_s2 <= 1'b0;
			fin_row_s2 <= '0;
		end else begin
			rd_pend_s1 <= (state_q == S_RD);
			rd_row_s1  <= k_q;
			op_vld_s1  <= (state_q == S_MUL);
			op_s1      <= issue_op;
			fin_vld_s2 <= op_vld_s1 && (op_s1.kind == K_D);
			fin_row_s2 <= op_s1.row;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q    <= in_data.mode;
						col_idx_q <= '0;
						k_q       <= '0;
						m_q       <= '0;
						if (in_data.mode == MODE_INTEGRATE || in_data.mode == MODE_ROTATE) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					k_q <= k_q + 2'd1;
					if (k_q == LAST_IDX) begin
						state_q <= S_RWAIT;
					end
				end
				S_RWAIT: begin
					m_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					m_q <= m_q + 4'd1;
					if (m_q == last_op) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// hold until the last product and write-back have left
					if (!op_vld_s1 && !fin_vld_s2) begin
						k_q <= '0;
						if (col_idx_q == LAST_IDX) begin
							state_q <= (mode_q == MODE_ROTATE) ? S_EMIT : S_IDLE;
						end else begin
							col_idx_q <= col_idx_q + 2'd1;
							state_q   <= S_RD;
						end
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			vec_q <= in_data;
		end
		if (rd_pend_s1) begin
			col_q[rd_row_s1] <= rd_data;
		end
		if (op_vld_s1) begin
			case (op_s1.kind)
				K_A: begin
					t1_q <= prod_q[63:16];
				end
				K_B: begin
					d_q[op_s1.row] <= {t1_q[T1_W-1], t1_q} - {prod_q[63], prod_q[63:16]};
				end
				K_C: begin
					hi_q <= prod_q[HI_W-1:0];
				end
				K_D: begin
					sum_q <= {hi_q[HI_W-1], hi_q} + {26'd0, prod_q[55:24]};
				end
				K_R: begin
					if (op_s1.row == 2'd0) begin
						racc_q <= term_ext;
					end else if (op_s1.row == 2'd1) begin
						racc_q <= rot_sum;
					end else begin
						res_part_q[col_idx_q] <= sat_word({{(SUM_W-ROT_W){rot_sum[ROT_W-1]}},
							rot_sum});
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/dcm_checker.sv =====
// ----------------------------------------------------------------------------
// dcm_checker
// Port-level checks of the attitude update block, bound to the top level.
// ----------------------------------------------------------------------------
module dcm_checker
	import dcm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input in_item_t          in_data,
	input logic              out_valid,
	input logic              out_stall,
	input out_item_t         out_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// integrate and rotate transfers keep the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall
		&& (in_data.mode == MODE_INTEGRATE || in_data.mode == MODE_ROTATE)
		|=> in_stall)
		else $error("block free right after an integrate or rotate transfer");

	// reload and unused modes finish at once
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall
		&& !(in_data.mode == MODE_INTEGRATE || in_data.mode == MODE_ROTATE)
		|=> !in_stall)
		else $error("block busy after a reload or unused mode");

	// a fresh result only follows a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

bind dcm_attitude_update dcm_checker u_chk (.*);
